@@ rtl/core/rgb2yuv_pkg.sv @@
`timescale 1ns / 1ps

package rgb2yuv_pkg;

    // Largest frame dimension the position counters support.
    localparam int MAX_DIM = 4096;

    // Field and register widths.
    localparam int LEVEL_W = 11;
    localparam int CFG_W   = 13;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = CNT_W + 1;
    localparam int SUM_W   = 20;
    localparam int QUO_W   = SUM_W - 8;
    localparam int OFS_W   = QUO_W + 1;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Reset values of the frame size registers.
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1920);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1080);

    // Chroma sample codes.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CB   = 2'd1;
    localparam logic [1:0] KIND_CR   = 2'd2;

    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic [DIM_W-1:0]          t_dim;

    // Position flags of one pixel, produced by the counters.
    typedef struct packed {
        logic col_odd;
        logic row_odd;
        logic frame_end;
    } t_pos;

    // Effective dimension: register value saturated to 2..MAX_DIM.
    function automatic t_dim eff_dim(input logic [CFG_W-1:0] v);
        t_dim res;
        if (32'(v) < 32'd2) begin
            res = DIM_W'(2);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    // Round by +128, floor shift by 8, add the offset, clamp to 0..255.
    function automatic logic [7:0] finish(
        input logic signed [SUM_W-1:0] s,
        input logic signed [OFS_W-1:0] offset
    );
        logic signed [SUM_W-1:0] t;
        logic signed [QUO_W-1:0] q;
        logic signed [OFS_W-1:0] r;
        logic [7:0]              res;
        t = s + SUM_W'(signed'(128));
        q = t[SUM_W-1:8];
        r = OFS_W'(q) + offset;
        if (r < 0) begin
            res = 8'd0;
        end else if (r > OFS_W'(signed'(255))) begin
            res = 8'd255;
        end else begin
            res = r[7:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/rgb_to_yuv420_converter.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// pixel     in         i_in_valid / o_in_stall    i_red_level, i_green_level, i_blue_level
// sample    out        o_out_valid / i_out_stall  o_luma, o_chroma, o_chroma_kind, o_frame_end
// config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// One pixel is accepted per cycle unless o_in_stall is high; its result passes
// through the input register, then the result register, with the color math between them.
// Synchronous active-low reset clears the valid bits, the position counters
// and restores the frame size registers to 1920 by 1080.
// A stall on the output holds the result register; the input register keeps
// accepting until it too is full, so o_in_stall follows i_out_stall.

module rgb_to_yuv420_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [10:0]                  i_red_level,
    input  logic signed [10:0]                  i_green_level,
    input  logic signed [10:0]                  i_blue_level,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_luma,
    output logic [7:0]                          o_chroma,
    output logic [1:0]                          o_chroma_kind,
    output logic                                o_frame_end,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgb2yuv_pkg::PADDR_W-1:0]     paddr,
    input  logic [rgb2yuv_pkg::PDATA_W-1:0]     pwdata,
    output logic [rgb2yuv_pkg::PDATA_W-1:0]     prdata,
    output logic                                pready
);

    rgb2yuv_pkg::t_dim   eff_width;
    rgb2yuv_pkg::t_dim   eff_height;
    rgb2yuv_pkg::t_pos   cur_pos;
    logic                adv_in;
    logic                adv_out;
    logic                accept;

    logic                r_s1_valid;
    rgb2yuv_pkg::t_level r_s1_red;
    rgb2yuv_pkg::t_level r_s1_green;
    rgb2yuv_pkg::t_level r_s1_blue;
    rgb2yuv_pkg::t_pos   r_s1_pos;

    logic [7:0]          n_luma;
    logic [7:0]          n_chroma;
    logic [1:0]          n_chroma_kind;
    logic                r_s2_valid;
    logic [7:0]          r_luma;
    logic [7:0]          r_chroma;
    logic [1:0]          r_chroma_kind;
    logic                r_frame_end;

    // Configuration registers.
    rgb2yuv_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_eff_width  (eff_width),
        .o_eff_height (eff_height)
    );

    // Pipeline flow control.
    assign adv_out    = !r_s2_valid || !i_out_stall;
    assign adv_in     = !r_s1_valid || adv_out;
    assign o_in_stall = !adv_in;
    assign accept     = i_in_valid && adv_in;

    // Position counters step once per accepted request.
    rgb2yuv_pos u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (accept),
        .i_eff_width  (eff_width),
        .i_eff_height (eff_height),
        .o_pos        (cur_pos)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv_in) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_red   <= i_red_level;
            r_s1_green <= i_green_level;
            r_s1_blue  <= i_blue_level;
            r_s1_pos   <= cur_pos;
        end
    end

    // Color conversion between the two registers.
    rgb2yuv_csc u_csc (
        .i_red         (r_s1_red),
        .i_green       (r_s1_green),
        .i_blue        (r_s1_blue),
        .i_pos         (r_s1_pos),
        .o_luma        (n_luma),
        .o_chroma      (n_chroma),
        .o_chroma_kind (n_chroma_kind)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv_out) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_luma        <= n_luma;
            r_chroma      <= n_chroma;
            r_chroma_kind <= n_chroma_kind;
            r_frame_end   <= r_s1_pos.frame_end;
        end
    end

    assign o_out_valid   = r_s2_valid;
    assign o_luma        = r_luma;
    assign o_chroma      = r_chroma;
    assign o_chroma_kind = r_chroma_kind;
    assign o_frame_end   = r_frame_end;

endmodule

@@ rtl/core/rgb2yuv_regs.sv @@
`timescale 1ns / 1ps

module rgb2yuv_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgb2yuv_pkg::PADDR_W-1:0]     paddr,
    input  logic [rgb2yuv_pkg::PDATA_W-1:0]     pwdata,
    output logic [rgb2yuv_pkg::PDATA_W-1:0]     prdata,
    output logic                                pready,
    output rgb2yuv_pkg::t_dim                   o_eff_width,
    output rgb2yuv_pkg::t_dim                   o_eff_height
);

    logic [rgb2yuv_pkg::CFG_W-1:0] r_frame_width;
    logic [rgb2yuv_pkg::CFG_W-1:0] r_frame_height;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= rgb2yuv_pkg::WIDTH_RESET;
            r_frame_height <= rgb2yuv_pkg::HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                rgb2yuv_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[rgb2yuv_pkg::CFG_W-1:0];
                end
                rgb2yuv_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[rgb2yuv_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (paddr[2])
            rgb2yuv_pkg::REG_FRAME_WIDTH: begin
                prdata = rgb2yuv_pkg::PDATA_W'(r_frame_width);
            end
            rgb2yuv_pkg::REG_FRAME_HEIGHT: begin
                prdata = rgb2yuv_pkg::PDATA_W'(r_frame_height);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // Saturated dimensions used by the position counters.
    assign o_eff_width  = rgb2yuv_pkg::eff_dim(r_frame_width);
    assign o_eff_height = rgb2yuv_pkg::eff_dim(r_frame_height);

endmodule

@@ rtl/core/rgb2yuv_pos.sv @@
`timescale 1ns / 1ps

module rgb2yuv_pos (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  rgb2yuv_pkg::t_dim  i_eff_width,
    input  rgb2yuv_pkg::t_dim  i_eff_height,
    output rgb2yuv_pkg::t_pos  o_pos
);

    logic [rgb2yuv_pkg::CNT_W-1:0] r_col;
    logic [rgb2yuv_pkg::CNT_W-1:0] r_row;
    logic [rgb2yuv_pkg::CNT_W-1:0] n_col;
    logic [rgb2yuv_pkg::CNT_W-1:0] n_row;
    rgb2yuv_pkg::t_dim             col_inc;
    rgb2yuv_pkg::t_dim             row_inc;
    logic                          last_col;
    logic                          last_row;

    // A counter at or past its limit counts as the last position.
    assign col_inc  = {1'b0, r_col} + rgb2yuv_pkg::DIM_W'(1);
    assign row_inc  = {1'b0, r_row} + rgb2yuv_pkg::DIM_W'(1);
    assign last_col = col_inc >= i_eff_width;
    assign last_row = row_inc >= i_eff_height;

    // Raster order stepping.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_inc[rgb2yuv_pkg::CNT_W-1:0];
        end else begin
            n_col = col_inc[rgb2yuv_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.col_odd   = r_col[0];
    assign o_pos.row_odd   = r_row[0];
    assign o_pos.frame_end = last_col && last_row;

endmodule

@@ rtl/core/rgb2yuv_csc.sv @@
`timescale 1ns / 1ps

module rgb2yuv_csc (
    input  rgb2yuv_pkg::t_level  i_red,
    input  rgb2yuv_pkg::t_level  i_green,
    input  rgb2yuv_pkg::t_level  i_blue,
    input  rgb2yuv_pkg::t_pos    i_pos,
    output logic [7:0]           o_luma,
    output logic [7:0]           o_chroma,
    output logic [1:0]           o_chroma_kind
);

    localparam int SW = rgb2yuv_pkg::SUM_W;
    localparam int OW = rgb2yuv_pkg::OFS_W;

    logic signed [SW-1:0] r_ext;
    logic signed [SW-1:0] g_ext;
    logic signed [SW-1:0] b_ext;
    logic signed [SW-1:0] sum_y;
    logic signed [SW-1:0] sum_cb;
    logic signed [SW-1:0] sum_cr;
    logic [7:0]           cb;
    logic [7:0]           cr;

    assign r_ext = SW'(i_red);
    assign g_ext = SW'(i_green);
    assign b_ext = SW'(i_blue);

    // BT.601 weighted sums with constant coefficients.
    assign sum_y  = r_ext * SW'(signed'(66)) + g_ext * SW'(signed'(129))
                  + b_ext * SW'(signed'(25));
    assign sum_cb = b_ext * SW'(signed'(112)) - r_ext * SW'(signed'(38))
                  - g_ext * SW'(signed'(74));
    assign sum_cr = r_ext * SW'(signed'(112)) - g_ext * SW'(signed'(94))
                  - b_ext * SW'(signed'(18));

    assign o_luma = rgb2yuv_pkg::finish(sum_y, OW'(signed'(16)));
    assign cb     = rgb2yuv_pkg::finish(sum_cb, OW'(signed'(128)));
    assign cr     = rgb2yuv_pkg::finish(sum_cr, OW'(signed'(128)));

    // Chroma on even columns only: Cb on even rows, Cr on odd rows.
    always_comb begin
        if (i_pos.col_odd) begin
            o_chroma      = 8'd0;
            o_chroma_kind = rgb2yuv_pkg::KIND_NONE;
        end else if (i_pos.row_odd) begin
            o_chroma      = cr;
            o_chroma_kind = rgb2yuv_pkg::KIND_CR;
        end else begin
            o_chroma      = cb;
            o_chroma_kind = rgb2yuv_pkg::KIND_CB;
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    // Cycles with no request moving on either channel before the run is declared hung.
    // A correct run only goes quiet during register accesses, drain waits and short stalls.
    localparam int HANG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_PERCENT = 7;

    localparam logic [rgb2yuv_pkg::PADDR_W-1:0] ADDR_FRAME_WIDTH  =
        {rgb2yuv_pkg::REG_FRAME_WIDTH, 2'b00};
    localparam logic [rgb2yuv_pkg::PADDR_W-1:0] ADDR_FRAME_HEIGHT =
        {rgb2yuv_pkg::REG_FRAME_HEIGHT, 2'b00};

    typedef struct {
        rgb2yuv_pkg::t_level red;
        rgb2yuv_pkg::t_level green;
        rgb2yuv_pkg::t_level blue;
    } t_rgb_pixel;

    typedef struct {
        logic [7:0] luma;
        logic [7:0] chroma;
        logic [1:0] kind;
        logic       frame_end;
    } t_yuv_sample;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    rgb2yuv_pkg::t_level                 i_red_level = '0;
    rgb2yuv_pkg::t_level                 i_green_level = '0;
    rgb2yuv_pkg::t_level                 i_blue_level = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [7:0]                          o_luma;
    logic [7:0]                          o_chroma;
    logic [1:0]                          o_chroma_kind;
    logic                                o_frame_end;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [rgb2yuv_pkg::PADDR_W-1:0]     paddr = '0;
    logic [rgb2yuv_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [rgb2yuv_pkg::PDATA_W-1:0]     prdata;
    logic                                pready;

    // Pixels waiting to be driven, and converted samples waiting to come out.
    t_rgb_pixel  pending_pixels[$];
    t_yuv_sample expected_yuv[$];

    // Shadow of the frame size registers and the raster position.
    logic [rgb2yuv_pkg::CFG_W-1:0] shadow_width = rgb2yuv_pkg::WIDTH_RESET;
    logic [rgb2yuv_pkg::CFG_W-1:0] shadow_height = rgb2yuv_pkg::HEIGHT_RESET;
    int                            column_pos = 0;
    int                            row_pos = 0;

    logic pixel_taken = 1'b0;
    logic no_idle = 1'b0;
    int   error_count = 0;
    int   quiet_cycles = 0;

    rgb_to_yuv420_converter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_red_level   (i_red_level),
        .i_green_level (i_green_level),
        .i_blue_level  (i_blue_level),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_luma        (o_luma),
        .o_chroma      (o_chroma),
        .o_chroma_kind (o_chroma_kind),
        .o_frame_end   (o_frame_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Register value saturated to the supported frame size range.
    function automatic int clamp_dim(input logic [rgb2yuv_pkg::CFG_W-1:0] v);
        if (v < 2) begin
            return 2;
        end
        if (v > rgb2yuv_pkg::MAX_DIM) begin
            return rgb2yuv_pkg::MAX_DIM;
        end
        return int'(v);
    endfunction

    // Weighted sum rounded, floor-divided by 256, offset and clamped to a byte.
    function automatic logic [7:0] scale_clamp(input int weighted, input int offset);
        int q;
        q = ((weighted + 128) >>> 8) + offset;
        if (q < 0) begin
            q = 0;
        end else if (q > 255) begin
            q = 255;
        end
        return 8'(q);
    endfunction

    // Convert one accepted pixel and advance the raster position.
    task automatic convert_pixel(input t_rgb_pixel px);
        t_yuv_sample yuv;
        int r;
        int g;
        int b;
        logic last_col;
        logic last_row;
        r = px.red;
        g = px.green;
        b = px.blue;
        last_col = (column_pos + 1 >= clamp_dim(shadow_width));
        last_row = (row_pos + 1 >= clamp_dim(shadow_height));
        yuv.luma = scale_clamp(66 * r + 129 * g + 25 * b, 16);
        if (column_pos[0]) begin
            yuv.chroma = 8'd0;
            yuv.kind = rgb2yuv_pkg::KIND_NONE;
        end else if (!row_pos[0]) begin
            yuv.chroma = scale_clamp(-38 * r - 74 * g + 112 * b, 128);
            yuv.kind = rgb2yuv_pkg::KIND_CB;
        end else begin
            yuv.chroma = scale_clamp(112 * r - 94 * g - 18 * b, 128);
            yuv.kind = rgb2yuv_pkg::KIND_CR;
        end
        yuv.frame_end = last_col && last_row;
        expected_yuv.push_back(yuv);
        if (last_col) begin
            column_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            column_pos++;
        end
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(
        input  logic                            wr,
        input  logic [rgb2yuv_pkg::PADDR_W-1:0] addr,
        input  logic [rgb2yuv_pkg::PDATA_W-1:0] wdata,
        output logic [rgb2yuv_pkg::PDATA_W-1:0] rdata
    );
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Write both frame size registers, read them back and update the shadow copy.
    task automatic set_frame_size(input logic [rgb2yuv_pkg::CFG_W-1:0] w,
                                  input logic [rgb2yuv_pkg::CFG_W-1:0] h);
        logic [rgb2yuv_pkg::PDATA_W-1:0] rd;
        apb_access(1'b1, ADDR_FRAME_WIDTH,
                   {$urandom} & ~rgb2yuv_pkg::PDATA_W'(13'h1FFF)
                   | rgb2yuv_pkg::PDATA_W'(w), rd);
        shadow_width = w;
        apb_access(1'b1, ADDR_FRAME_HEIGHT,
                   {$urandom} & ~rgb2yuv_pkg::PDATA_W'(13'h1FFF)
                   | rgb2yuv_pkg::PDATA_W'(h), rd);
        shadow_height = h;
        apb_access(1'b0, ADDR_FRAME_WIDTH, '0, rd);
        if (rd != rgb2yuv_pkg::PDATA_W'(w)) begin
            report_mismatch("frame_width readback", int'(rd), int'(w));
        end
        apb_access(1'b0, ADDR_FRAME_HEIGHT, '0, rd);
        if (rd != rgb2yuv_pkg::PDATA_W'(h)) begin
            report_mismatch("frame_height readback", int'(rd), int'(h));
        end
    endtask

    task automatic add_pixel(input int r, input int g, input int b);
        t_rgb_pixel px;
        px.red = rgb2yuv_pkg::t_level'(r);
        px.green = rgb2yuv_pkg::t_level'(g);
        px.blue = rgb2yuv_pkg::t_level'(b);
        pending_pixels.push_back(px);
    endtask

    // Wait until every pixel is driven and every sample has come out,
    // then let the two pipeline stages settle.
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || i_in_valid || expected_yuv.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly ordinary 8-bit levels, with raw bit patterns and range corners mixed in.
    function automatic int random_level();
        case ($urandom_range(3))
            0, 1: return $urandom_range(255);
            2: return $urandom_range(2047) - 1024;
            default: begin
                case ($urandom_range(5))
                    0: return -1024;
                    1: return -1;
                    2: return 0;
                    3: return 255;
                    4: return 256;
                    default: return 1023;
                endcase
            end
        endcase
    endfunction

    function automatic logic [rgb2yuv_pkg::CFG_W-1:0] out_of_range_dim();
        case ($urandom_range(2))
            0: return 13'd0;
            1: return 13'd1;
            default: return rgb2yuv_pkg::CFG_W'($urandom_range(4097, 8191));
        endcase
    endfunction

    // Pixel driver: a new request only once the previous one has been taken.
    always @(negedge i_clk) begin : drive_pixels
        t_rgb_pixel px;
        if (i_rst_n && (!i_in_valid || pixel_taken)) begin
            if (pending_pixels.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
                px = pending_pixels.pop_front();
                i_in_valid <= 1'b1;
                i_red_level <= px.red;
                i_green_level <= px.green;
                i_blue_level <= px.blue;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Sample side backpressure.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_out_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Sample checker, pixel predictor and hang watchdog.
    always @(posedge i_clk) begin : check_samples
        t_yuv_sample want;
        t_rgb_pixel px;
        logic in_fire;
        logic out_fire;
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !i_out_stall;
        pixel_taken <= in_fire;
        if (out_fire) begin
            if (expected_yuv.size() == 0) begin
                report_mismatch("sample with no pixel pending, luma", o_luma, 0);
            end else begin
                want = expected_yuv.pop_front();
                if (o_luma !== want.luma) begin
                    report_mismatch("luma", o_luma, want.luma);
                end
                if (o_chroma !== want.chroma) begin
                    report_mismatch("chroma", o_chroma, want.chroma);
                end
                if (o_chroma_kind !== want.kind) begin
                    report_mismatch("chroma_kind", o_chroma_kind, want.kind);
                end
                if (o_frame_end !== want.frame_end) begin
                    report_mismatch("frame_end", o_frame_end, want.frame_end);
                end
            end
        end
        if (in_fire) begin
            px.red = i_red_level;
            px.green = i_green_level;
            px.blue = i_blue_level;
            convert_pixel(px);
        end
        if (in_fire || out_fire || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("rgb_to_yuv420_converter verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [rgb2yuv_pkg::PDATA_W-1:0] rd;
        logic [rgb2yuv_pkg::CFG_W-1:0] w;
        logic [rgb2yuv_pkg::CFG_W-1:0] h;
        int sent;
        int phase;
        int count;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of the frame size registers.
        apb_access(1'b0, ADDR_FRAME_WIDTH, '0, rd);
        if (rd != rgb2yuv_pkg::PDATA_W'(rgb2yuv_pkg::WIDTH_RESET)) begin
            report_mismatch("frame_width after reset", int'(rd),
                            int'(rgb2yuv_pkg::WIDTH_RESET));
        end
        apb_access(1'b0, ADDR_FRAME_HEIGHT, '0, rd);
        if (rd != rgb2yuv_pkg::PDATA_W'(rgb2yuv_pkg::HEIGHT_RESET)) begin
            report_mismatch("frame_height after reset", int'(rd),
                            int'(rgb2yuv_pkg::HEIGHT_RESET));
        end

        // Level extremes and primaries in the reset frame size.
        add_pixel(0, 0, 0);
        add_pixel(1023, 1023, 1023);
        add_pixel(-1024, -1024, -1024);
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 255, 255);
        add_pixel(-1024, 1023, -1024);
        add_pixel(1023, -1024, 1023);
        wait_drained();

        // Smallest frame, entered mid-row so the column wraps at once.
        set_frame_size(13'd2, 13'd2);
        add_pixel(1023, -1024, -1024);
        add_pixel(-1024, 1023, 1023);
        add_pixel(1023, -1024, -1024);
        add_pixel(-1024, -1024, 1023);
        wait_drained();

        // Below-range sizes saturate to two.
        set_frame_size(13'd1, 13'd0);
        add_pixel(128, 64, 32);
        add_pixel(-1, -1, -1);
        add_pixel(256, 256, 256);
        add_pixel(1023, 0, -1024);
        wait_drained();

        // Above-range sizes saturate to the largest frame.
        set_frame_size(13'h1FFF, 13'h1FFF);
        add_pixel(200, 100, 50);
        add_pixel(-512, 511, 0);
        wait_drained();

        // Width shrunk below the current column, odd height.
        set_frame_size(13'd2, 13'd3);
        add_pixel(0, 0, 1023);
        add_pixel(1023, 0, 0);
        add_pixel(17, 34, 51);
        add_pixel(-1024, 0, 1023);
        add_pixel(90, 180, 250);
        wait_drained();

        // Random frames: mostly small even sizes, with odd, saturated and huge ones.
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    w = rgb2yuv_pkg::CFG_W'(2 * $urandom_range(1, 6));
                    h = rgb2yuv_pkg::CFG_W'(2 * $urandom_range(1, 4));
                end
                6: begin
                    w = rgb2yuv_pkg::CFG_W'(2 * $urandom_range(1, 4) + 1);
                    h = rgb2yuv_pkg::CFG_W'(2 * $urandom_range(0, 3) + 1);
                end
                7: begin
                    w = out_of_range_dim();
                    h = out_of_range_dim();
                end
                8: begin
                    w = rgb2yuv_pkg::CFG_W'(rgb2yuv_pkg::MAX_DIM);
                    h = 13'd2;
                end
                default: begin
                    w = 13'd2;
                    h = rgb2yuv_pkg::CFG_W'(rgb2yuv_pkg::MAX_DIM);
                end
            endcase
            set_frame_size(w, h);
            // One long phase runs with neither side idling.
            no_idle = (phase == 2);
            count = no_idle ? 120 : $urandom_range(30, 80);
            repeat (count) begin
                add_pixel(random_level(), random_level(), random_level());
            end
            sent += count;
            phase++;
            wait_drained();
            no_idle = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("rgb_to_yuv420_converter verification clean");
        end else begin
            $display("rgb_to_yuv420_converter verification failed");
        end
        $finish;
    end

endmodule
